FILE: src/lams_pkg.sv
// ----------------------------------------------------------------------------
// lams_pkg: shared types and constants of the LED/ADC measurement sequencer
// Item types of the request and response channels, action and register
// codes, reset values of the control registers and the step record.
// ----------------------------------------------------------------------------
`default_nettype none

package lams_pkg;

   // Fixed geometry
   localparam int CHANNELS     = 4;
   localparam int RUN_LIMIT    = 4;   // most report items one step can produce
   localparam int SCHED_MAX_DEF = 4;
   localparam int VALUE_BITS_DEF = 24;
   localparam int MEAS_W       = 24;

   // Action codes of a request item
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_STOP    = 3'd2;
   localparam logic [2:0] ACT_MODE1   = 3'd3;
   localparam logic [2:0] ACT_MODE3   = 3'd4;
   localparam logic [2:0] ACT_RESULT  = 3'd5;
   localparam logic [2:0] ACT_COLLECT = 3'd6;

   // Control register indexes
   localparam logic [2:0] CSR_WAIT_TICKS    = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd1;
   localparam logic [2:0] CSR_MUX_SELECT    = 3'd2;
   localparam logic [2:0] CSR_SCHED_LEN     = 3'd3;
   localparam logic [2:0] CSR_SCHED_CHAN    = 3'd4;

   // Control register reset values
   localparam logic [15:0] WAIT_TICKS_RST    = 16'd400;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
   localparam logic [1:0]  MUX_SELECT_RST    = 2'd0;
   localparam logic [2:0]  SCHED_LEN_RST     = 3'd4;
   localparam logic [7:0]  SCHED_CHAN_RST    = 8'd228;

   // Measurement phase
   typedef enum logic [4:0] {
      PH_WAIT    = 5'b00001,
      PH_STANDBY = 5'b00010,
      PH_MEAS    = 5'b00100,
      PH_DONE    = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [2:0]               action;
      logic                     adc_ok;
      logic signed [MEAS_W-1:0] meas_value;
   } req_item_type;

   typedef struct packed {
      logic [2:0]               led_pins;
      logic                     adc_start_req;
      logic                     adc_stop_req;
      logic                     avg_request;
      logic                     timeout_error;
      logic                     report_valid;
      logic                     report_mode;
      logic [1:0]               report_channel;
      logic signed [MEAS_W-1:0] report_value;
      logic                     report_last;
   } rsp_item_type;

   // Everything one step produces, before it is split into items
   typedef struct packed {
      logic [2:0]                           led_pins;
      logic                                 adc_start_req;
      logic                                 adc_stop_req;
      logic                                 avg_request;
      logic                                 timeout_error;
      logic [2:0]                           rep_count;
      logic                                 rep_mode;
      logic [RUN_LIMIT-1:0][1:0]            rep_channel;
      logic [RUN_LIMIT-1:0][MEAS_W-1:0]     rep_value;
   } step_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  index;
      logic [15:0] wdata;
   } csr_write_type;

endpackage

`default_nettype wire

FILE: src/lams_core.sv
// ----------------------------------------------------------------------------
// lams_core: sequencer state and step logic
// Holds control registers and task state; while commit is high, evaluates one
// registered item per cycle, giving the step record for the response buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module lams_core #(
   parameter int SCHED_MAX  = lams_pkg::SCHED_MAX_DEF,
   parameter int VALUE_BITS = lams_pkg::VALUE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lams_pkg::csr_write_type csr_wr,
   input  wire logic                   commit,
   input  wire lams_pkg::req_item_type item,
   output lams_pkg::step_type          step
);

   localparam int RUN_MAX = (SCHED_MAX < lams_pkg::RUN_LIMIT) ? SCHED_MAX : lams_pkg::RUN_LIMIT;

   // Control registers
   logic [15:0] wait_ticks_ff, timeout_ticks_ff;
   logic [1:0]  mux_select_ff;
   logic [2:0]  sched_len_ff;
   logic [7:0]  sched_chan_ff;

   // Task state
   logic                     running_ff, running_in;
   logic                     mode_ff, mode_in;
   lams_pkg::phase_type      phase_ff, phase_in;
   logic [15:0]              tick_ff, tick_in, tick_inc;
   logic [2:0]               idx_ff, idx_in, idx_next;
   logic                     done_ff, done_in;
   logic [lams_pkg::CHANNELS-1:0] chan_on_ff, chan_on_in;
   logic [2:0]               pin_ff, pin_in;
   logic [VALUE_BITS-1:0]    entry_ff [RUN_MAX];
   logic [VALUE_BITS-1:0]    entry_in [RUN_MAX];
   logic [VALUE_BITS-1:0]    single_ff, single_in;

   // Step helpers
   logic [2:0]  eff_len;
   logic [1:0]  cur_chan;
   logic        led_req, led_on;
   logic [1:0]  led_ch;
   logic        do_init;
   logic [VALUE_BITS-1:0] meas_store;
   logic [lams_pkg::RUN_LIMIT-1:0][lams_pkg::MEAS_W-1:0] entry_out;
   logic        want_mode;

   function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [23:0] v);
      logic signed [31:0] s;
      s = 32'(v);
      return s[VALUE_BITS-1:0];
   endfunction

   function automatic logic [23:0] to_out(input logic signed [VALUE_BITS-1:0] v);
      logic signed [31:0] s;
      s = 32'(v);
      return s[23:0];
   endfunction

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ticks_ff    <= lams_pkg::WAIT_TICKS_RST;
         timeout_ticks_ff <= lams_pkg::TIMEOUT_TICKS_RST;
         mux_select_ff    <= lams_pkg::MUX_SELECT_RST;
         sched_len_ff     <= lams_pkg::SCHED_LEN_RST;
         sched_chan_ff    <= lams_pkg::SCHED_CHAN_RST;
      end else if (csr_wr.valid) begin
         unique case (csr_wr.index)
            lams_pkg::CSR_WAIT_TICKS:    wait_ticks_ff    <= csr_wr.wdata;
            lams_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wr.wdata;
            lams_pkg::CSR_MUX_SELECT:    mux_select_ff    <= csr_wr.wdata[1:0];
            lams_pkg::CSR_SCHED_LEN:     sched_len_ff     <= csr_wr.wdata[2:0];
            lams_pkg::CSR_SCHED_CHAN:    sched_chan_ff    <= csr_wr.wdata[7:0];
            default: ;
         endcase
      end
   end

   // Clamp schedule length to the stored entries; zero counts as one
   always_comb begin
      eff_len = sched_len_ff;
      if (eff_len == 3'd0) eff_len = 3'd1;
      if (eff_len > 3'(RUN_MAX)) eff_len = 3'(RUN_MAX);
   end

   assign cur_chan   = sched_chan_ff[2*idx_ff[1:0] +: 2];
   assign tick_inc   = tick_ff + 16'd1;
   assign idx_next   = idx_ff + 3'd1;
   assign meas_store = to_store(item.meas_value);
   assign want_mode  = (item.action == lams_pkg::ACT_MODE3);

   // Widen stored entries to the report format
   always_comb begin
      entry_out = '0;
      for (int e = 0; e < RUN_MAX; e++) begin
         entry_out[e] = to_out(entry_ff[e]);
      end
   end

   // Evaluate one step
   always_comb begin
      running_in = running_ff;
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      idx_in     = idx_ff;
      done_in    = done_ff;
      single_in  = single_ff;
      for (int e = 0; e < RUN_MAX; e++) entry_in[e] = entry_ff[e];
      led_req = 1'b0;
      led_on  = 1'b0;
      led_ch  = cur_chan;
      do_init = 1'b0;
      step    = '0;

      unique case (item.action) inside
         lams_pkg::ACT_TICK: begin
            if (running_ff) begin
               unique case (phase_ff)
                  lams_pkg::PH_STANDBY: begin
                     if (!mode_ff && tick_inc < wait_ticks_ff) begin
                        tick_in = tick_inc;
                        led_req = 1'b1;
                        led_on  = 1'b1;
                     end else begin
                        step.avg_request = 1'b1;
                        phase_in = lams_pkg::PH_MEAS;
                        tick_in  = '0;
                     end
                  end
                  lams_pkg::PH_MEAS: begin
                     tick_in = tick_inc;
                     if (tick_inc > timeout_ticks_ff) begin
                        step.timeout_error = 1'b1;
                        tick_in  = '0;
                        phase_in = lams_pkg::PH_ERROR;
                     end else if (done_ff) begin
                        phase_in = lams_pkg::PH_DONE;
                        done_in  = 1'b0;
                     end
                  end
                  lams_pkg::PH_DONE: begin
                     tick_in = '0;
                     if (!mode_ff) begin
                        led_req = 1'b1;
                        if (idx_next >= eff_len) begin
                           idx_in          = '0;
                           step.rep_count  = eff_len;
                           for (int k = 0; k < lams_pkg::RUN_LIMIT; k++) begin
                              step.rep_channel[k] = sched_chan_ff[2*k +: 2];
                              step.rep_value[k]   = entry_out[k];
                           end
                           for (int e = 0; e < RUN_MAX; e++) entry_in[e] = '0;
                           phase_in = lams_pkg::PH_WAIT;
                        end else begin
                           idx_in   = idx_next;
                           phase_in = lams_pkg::PH_STANDBY;
                        end
                     end else begin
                        step.rep_count    = 3'd1;
                        step.rep_mode     = 1'b1;
                        step.rep_value[0] = to_out(single_ff);
                        single_in         = '0;
                        phase_in          = lams_pkg::PH_WAIT;
                     end
                  end
                  lams_pkg::PH_ERROR: do_init = 1'b1;
                  default: ;
               endcase
            end
         end
         lams_pkg::ACT_START: begin
            if (!running_ff) begin
               step.adc_start_req = 1'b1;
               if (item.adc_ok) running_in = 1'b1;
            end
         end
         lams_pkg::ACT_STOP: begin
            step.adc_stop_req = running_ff;
            do_init = 1'b1;
         end
         lams_pkg::ACT_MODE1, lams_pkg::ACT_MODE3: begin
            if (mode_ff != want_mode) begin
               step.adc_stop_req = 1'b1;
               do_init = 1'b1;
            end
         end
         lams_pkg::ACT_RESULT: begin
            done_in = 1'b1;
            if (!mode_ff) begin
               for (int e = 0; e < RUN_MAX; e++) begin
                  if (idx_ff == 3'(e)) entry_in[e] = meas_store;
               end
            end else begin
               single_in = meas_store;
            end
         end
         lams_pkg::ACT_COLLECT: phase_in = lams_pkg::PH_DONE;
         default: ;
      endcase

      // Drive one LED channel; a repeated request leaves the pin alone
      chan_on_in = chan_on_ff;
      pin_in     = pin_ff;
      if (led_req && chan_on_ff[led_ch] != led_on) begin
         chan_on_in[led_ch] = led_on;
         if (led_ch != 2'd3) begin
            pin_in[led_ch] = led_on;
         end else if (mux_select_ff != 2'd0) begin
            pin_in[mux_select_ff - 2'd1] = led_on;
         end
      end

      // Reinitialize the task
      if (do_init) begin
         running_in = 1'b0;
         mode_in    = 1'b0;
         phase_in   = lams_pkg::PH_WAIT;
         tick_in    = '0;
         idx_in     = '0;
         done_in    = 1'b0;
         chan_on_in = '0;
         pin_in     = '0;
         single_in  = '0;
         for (int e = 0; e < RUN_MAX; e++) entry_in[e] = '0;
      end

      // Mode start: switch mode after reinit, then go to standby if running
      if ((item.action == lams_pkg::ACT_MODE1 || item.action == lams_pkg::ACT_MODE3)) begin
         if (mode_ff != want_mode) begin
            running_in = 1'b1;
            mode_in    = want_mode;
         end
         if (running_in) phase_in = lams_pkg::PH_STANDBY;
      end

      step.led_pins = pin_in;
   end

   // Advance state on each committed item
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         mode_ff    <= 1'b0;
         phase_ff   <= lams_pkg::PH_WAIT;
         tick_ff    <= '0;
         idx_ff     <= '0;
         done_ff    <= 1'b0;
         chan_on_ff <= '0;
         pin_ff     <= '0;
         single_ff  <= '0;
         for (int e = 0; e < RUN_MAX; e++) entry_ff[e] <= '0;
      end else if (commit) begin
         running_ff <= running_in;
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         idx_ff     <= idx_in;
         done_ff    <= done_in;
         chan_on_ff <= chan_on_in;
         pin_ff     <= pin_in;
         single_ff  <= single_in;
         for (int e = 0; e < RUN_MAX; e++) entry_ff[e] <= entry_in[e];
      end
   end

endmodule

`default_nettype wire

FILE: src/lams_rsp_buf.sv
// ----------------------------------------------------------------------------
// lams_rsp_buf: response buffer and item splitter
// Two-entry buffer of step records; the head record is sent as one item,
// or as one item per report when the step carries reports.
// ----------------------------------------------------------------------------
`default_nettype none

module lams_rsp_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lams_pkg::step_type  push_step,
   output logic                     full,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lams_pkg::rsp_item_type   rsp_item
);

   lams_pkg::step_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] item_ff, item_in;
   logic       take, pop;
   logic [2:0] n_items;
   lams_pkg::step_type head;

   assign head      = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   assign n_items   = (head.rep_count == 3'd0) ? 3'd1 : head.rep_count;
   assign pop       = take && (3'({1'b0, item_ff}) + 3'd1 == n_items);

   // Build the outgoing item from the head record
   always_comb begin
      rsp_item = '0;
      rsp_item.led_pins      = head.led_pins;
      rsp_item.adc_start_req = head.adc_start_req;
      rsp_item.adc_stop_req  = head.adc_stop_req;
      rsp_item.avg_request   = head.avg_request;
      rsp_item.timeout_error = head.timeout_error;
      rsp_item.report_last   = (3'({1'b0, item_ff}) + 3'd1 == n_items);
      if (head.rep_count != 3'd0) begin
         rsp_item.report_valid   = 1'b1;
         rsp_item.report_mode    = head.rep_mode;
         rsp_item.report_channel = head.rep_channel[item_ff];
         rsp_item.report_value   = head.rep_value[item_ff];
      end
   end

   // Advance pointers and the item index
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      item_in   = pop ? 2'd0 : (take ? item_ff + 2'd1 : item_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         item_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         item_ff   <= item_in;
      end
   end

   // Store pushed records
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_step;
   end

endmodule

`default_nettype wire

FILE: src/led_adc_measurement_sequencer.sv
// ----------------------------------------------------------------------------
// led_adc_measurement_sequencer: tick-driven LED/ADC measurement sequencer
// Top level: input register, step logic and response buffer.
// ----------------------------------------------------------------------------
// Each request item (tick, start, stop, mode start, result, collect done) is
// taken into an input register and evaluated from there once the response
// buffer has room; a new item can be taken every cycle unless the buffer is
// full and the input register still holds an item. A step gives one response
// item, or one item per schedule entry (up to four) when a schedule run ends;
// a two-step buffer lets the request side keep going while a response waits.
// Control registers are written through the csr port, which is always ready;
// write them only while no item is in flight: the block does not enforce it.
`default_nettype none

module led_adc_measurement_sequencer #(
   parameter int SCHED_MAX  = lams_pkg::SCHED_MAX_DEF,
   parameter int VALUE_BITS = lams_pkg::VALUE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lams_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lams_pkg::rsp_item_type      rsp_item,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [15:0]            csr_wdata
);

   lams_pkg::req_item_type  in_ff;
   logic                    in_valid_ff, in_valid_in;
   logic                    buf_full, commit, req_take;
   lams_pkg::step_type      step;
   lams_pkg::csr_write_type csr_wr;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;

   // Hold the input register while the response buffer is full
   assign commit    = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take ? 1'b1 : (commit ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_ff <= req_item;
   end

   lams_core #(
      .SCHED_MAX  (SCHED_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .commit (commit),
      .item   (in_ff),
      .step   (step)
   );

   lams_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (commit),
      .push_step (step),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // A step without reports is a single item
   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.report_valid |-> rsp_item.report_last)
      else $error("plain step item not marked last");

   // A taken item that is not last is followed by more of the same step
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_item.report_last |=> rsp_valid)
      else $error("report run broken off");

   // A mode 3 report is one item
   a_mode3_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.report_valid && rsp_item.report_mode
      |-> rsp_item.report_last)
      else $error("mode 3 report spans several items");

   // Timeout and reports come from different phases
   a_timeout_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.timeout_error |-> !rsp_item.report_valid)
      else $error("timeout together with a report");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LED/ADC measurement sequencer
// A directed table covers the action codes, value extremes and schedule
// wrap-around. Random schedule and single-shot runs then follow under
// several register settings, the widest limits included. A local model of
// the sequencer predicts every response item.
// ----------------------------------------------------------------------------

module tb_top;

   // Clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   lams_pkg::req_item_type req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   lams_pkg::rsp_item_type rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [2:0]             csr_index = '0;
   logic [15:0]            csr_wdata = '0;

   led_adc_measurement_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Local copy of the control registers
   logic [15:0] cfg_wait;
   logic [15:0] cfg_timeout;
   logic [1:0]  cfg_mux;
   logic [2:0]  cfg_len;
   logic [7:0]  cfg_chan;

   // Local copy of the sequencer state
   logic                j_running;
   logic                m_mode;
   lams_pkg::phase_type m_phase;
   logic [15:0]         m_ticks;
   logic [2:0]          m_idx;
   logic                m_done;
   logic [3:0]          m_ch_on;
   logic [2:0]          m_pins;
   logic [lams_pkg::MEAS_W-1:0] m_entry [lams_pkg::RUN_LIMIT];
   logic [lams_pkg::MEAS_W-1:0] m_single;

   // Response items still owed by the block, oldest first
   lams_pkg::rsp_item_type awaited_rsp [$];

   int n_errors = 0;
   int n_req = 0;
   int n_rsp = 0;
   int n_reports = 0;
   int n_settings = 0;
   int burst_left = 0;

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (got !== want) begin
         $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
         n_errors++;
      end
   endtask

   task automatic clear_task_state();
      m_ticks   = '0;
      m_idx     = '0;
      m_mode    = 1'b0;
      j_running = 1'b0;
      m_phase   = lams_pkg::PH_WAIT;
      m_done    = 1'b0;
      m_ch_on   = '0;
      m_pins    = '0;
      for (int i = 0; i < lams_pkg::RUN_LIMIT; i++) m_entry[i] = '0;
      m_single  = '0;
   endtask

   // Schedule length as used: zero counts as one, above the limit saturates
   function automatic logic [2:0] run_len();
      logic [2:0] n;
      n = cfg_len;
      if (n == 0) n = 3'd1;
      if (n > lams_pkg::RUN_LIMIT) n = 3'(lams_pkg::RUN_LIMIT);
      return n;
   endfunction

   function automatic logic [1:0] slot_chan(input logic [2:0] slot);
      return cfg_chan[slot[1:0]*2 +: 2];
   endfunction

   // Switch one LED channel; channel 3 follows the mux, a repeat is ignored
   task automatic led_set(input logic [1:0] ch, input logic on);
      logic [1:0] pin;
      logic       has_pin;
      if (m_ch_on[ch] == on) return;
      m_ch_on[ch] = on;
      has_pin = 1'b1;
      pin = ch;
      if (ch == 2'd3) begin
         if (cfg_mux != 0) pin = cfg_mux - 2'd1;
         else has_pin = 1'b0;
      end
      if (has_pin) m_pins[pin] = on;
   endtask

   // Advance the local sequencer by one item and queue the items it owes
   task automatic step_sequencer(input lams_pkg::req_item_type it);
      logic                        st, sp, av, tm, rmode, to_mode3;
      int                          nrep, count;
      logic [1:0]                  rch [lams_pkg::RUN_LIMIT];
      logic [lams_pkg::MEAS_W-1:0] rval [lams_pkg::RUN_LIMIT];
      lams_pkg::rsp_item_type      r;
      st = 1'b0; sp = 1'b0; av = 1'b0; tm = 1'b0; rmode = 1'b0;
      nrep = 0;
      for (int k = 0; k < lams_pkg::RUN_LIMIT; k++) begin
         rch[k] = '0;
         rval[k] = '0;
      end
      case (it.action) inside
         lams_pkg::ACT_TICK: begin
            if (j_running) begin
               if (m_phase != lams_pkg::PH_WAIT) m_ticks = m_ticks + 16'd1;
               case (m_phase)
                  lams_pkg::PH_STANDBY: begin
                     if (!m_mode && m_ticks < cfg_wait) begin
                        led_set(slot_chan(m_idx), 1'b1);
                     end else begin
                        av = 1'b1;
                        m_phase = lams_pkg::PH_MEAS;
                        m_ticks = '0;
                     end
                  end
                  lams_pkg::PH_MEAS: begin
                     if (m_ticks > cfg_timeout) begin
                        tm = 1'b1;
                        m_ticks = '0;
                        m_phase = lams_pkg::PH_ERROR;
                     end else if (m_done) begin
                        m_phase = lams_pkg::PH_DONE;
                        m_done = 1'b0;
                     end
                  end
                  lams_pkg::PH_DONE: begin
                     m_ticks = '0;
                     if (!m_mode) begin
                        led_set(slot_chan(m_idx), 1'b0);
                        m_idx = m_idx + 3'd1;
                        if (m_idx >= run_len()) begin
                           // end of schedule: report every entry, then clear all
                           m_idx = '0;
                           nrep = int'(run_len());
                           for (int k = 0; k < nrep; k++) begin
                              rch[k] = slot_chan(k[2:0]);
                              rval[k] = m_entry[k];
                           end
                           for (int k = 0; k < lams_pkg::RUN_LIMIT; k++) m_entry[k] = '0;
                           m_phase = lams_pkg::PH_WAIT;
                        end else begin
                           m_phase = lams_pkg::PH_STANDBY;
                        end
                     end else begin
                        nrep = 1;
                        rmode = 1'b1;
                        rval[0] = m_single;
                        m_single = '0;
                        m_phase = lams_pkg::PH_WAIT;
                     end
                  end
                  lams_pkg::PH_ERROR: clear_task_state();
                  default: ;
               endcase
            end
         end
         lams_pkg::ACT_START: begin
            if (!j_running) begin
               st = 1'b1;
               if (it.adc_ok) j_running = 1'b1;
            end
         end
         lams_pkg::ACT_STOP: begin
            if (j_running) sp = 1'b1;
            clear_task_state();
         end
         lams_pkg::ACT_MODE1, lams_pkg::ACT_MODE3: begin
            to_mode3 = (it.action == lams_pkg::ACT_MODE3);
            if (m_mode != to_mode3) begin
               sp = 1'b1;
               clear_task_state();
               j_running = 1'b1;
               m_mode = to_mode3;
            end
            if (j_running) m_phase = lams_pkg::PH_STANDBY;
         end
         lams_pkg::ACT_RESULT: begin
            // values are already at the stored width, no wrap needed
            m_done = 1'b1;
            if (!m_mode) begin
               if (m_idx < lams_pkg::SCHED_MAX_DEF) m_entry[m_idx[1:0]] = it.meas_value;
            end else begin
               m_single = it.meas_value;
            end
         end
         lams_pkg::ACT_COLLECT: m_phase = lams_pkg::PH_DONE;
         default: ;
      endcase
      count = (nrep == 0) ? 1 : nrep;
      for (int k = 0; k < count; k++) begin
         r.led_pins       = m_pins;
         r.adc_start_req  = st;
         r.adc_stop_req   = sp;
         r.avg_request    = av;
         r.timeout_error  = tm;
         r.report_valid   = (nrep != 0);
         r.report_mode    = (nrep != 0) ? rmode : 1'b0;
         r.report_channel = (nrep != 0) ? rch[k] : 2'd0;
         r.report_value   = (nrep != 0) ? rval[k] : '0;
         r.report_last    = (k == count - 1);
         awaited_rsp.push_back(r);
      end
   endtask

   function automatic lams_pkg::req_item_type mk_req(input logic [2:0] act,
                                                     input logic ok,
                                                     input logic [lams_pkg::MEAS_W-1:0] val);
      lams_pkg::req_item_type it;
      it.action = act;
      it.adc_ok = ok;
      it.meas_value = val;
      return it;
   endfunction

   // Plain status item with no report
   function automatic lams_pkg::rsp_item_type mk_status(input logic st, input logic sp,
                                                        input logic av);
      lams_pkg::rsp_item_type r;
      r = '0;
      r.adc_start_req = st;
      r.adc_stop_req  = sp;
      r.avg_request   = av;
      r.report_last   = 1'b1;
      return r;
   endfunction

   // Send one item: bursts of random length, random gaps between them
   task automatic send_req(input lams_pkg::req_item_type it);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
            burst_left = 40;
         end else begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      n_req++;
      step_sequencer(it);
   endtask

   // Drop valid and let every owed item drain
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         lams_pkg::CSR_WAIT_TICKS:    cfg_wait    = data;
         lams_pkg::CSR_TIMEOUT_TICKS: cfg_timeout = data;
         lams_pkg::CSR_MUX_SELECT:    cfg_mux     = data[1:0];
         lams_pkg::CSR_SCHED_LEN:     cfg_len     = data[2:0];
         lams_pkg::CSR_SCHED_CHAN:    cfg_chan    = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Write all registers; upper bits of the narrow ones carry junk
   task automatic apply_setting(input logic [15:0] w, input logic [15:0] t,
                                input logic [1:0] mx, input logic [2:0] len,
                                input logic [7:0] ch);
      logic [15:0] junk;
      junk = 16'($urandom());
      drain();
      csr_write(lams_pkg::CSR_WAIT_TICKS, w);
      csr_write(lams_pkg::CSR_TIMEOUT_TICKS, t);
      csr_write(lams_pkg::CSR_MUX_SELECT, {junk[15:2], mx});
      csr_write(lams_pkg::CSR_SCHED_LEN, {junk[15:3], len});
      csr_write(lams_pkg::CSR_SCHED_CHAN, {junk[15:8], ch});
      n_settings++;
   endtask

   // Random request fields of the given action
   function automatic lams_pkg::req_item_type rnd_req(input logic [2:0] act);
      return mk_req(act, 1'($urandom_range(0, 1)), 24'($urandom()));
   endfunction

   // Well-formed schedule run with random timing and outcome per entry
   task automatic run_schedule();
      int n, ticks, pick;
      send_req(mk_req(lams_pkg::ACT_START, 1'b1, 24'($urandom())));
      send_req(rnd_req(lams_pkg::ACT_MODE1));
      n = int'(run_len()) + int'($urandom_range(0, 1));
      for (int e = 0; e < n; e++) begin
         ticks = (cfg_wait < 6) ? $urandom_range(0, cfg_wait + 1) : $urandom_range(0, 3);
         repeat (ticks) send_req(rnd_req(lams_pkg::ACT_TICK));
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
            send_req(rnd_req(lams_pkg::ACT_RESULT));
            send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
            send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
         end else if (pick <= 7) begin
            send_req(rnd_req(lams_pkg::ACT_COLLECT));
            send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
         end else if (pick == 8) begin
            // let the measurement wait run out
            repeat ((cfg_timeout < 12) ? cfg_timeout + 4 : 4)
               send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
         end else begin
            send_req(rnd_req(3'($urandom_range(0, 6))));
         end
      end
   endtask

   task automatic run_single();
      send_req(mk_req(lams_pkg::ACT_START, 1'b1, 24'($urandom())));
      send_req(rnd_req(lams_pkg::ACT_MODE3));
      send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
      repeat ($urandom_range(0, 2))
         send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
      send_req(mk_req(lams_pkg::ACT_RESULT, 1'b0, 24'($urandom())));
      send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
      send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
   endtask

   task automatic random_phase(input int items);
      int target, pick;
      target = n_req + items;
      while (n_req < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) run_schedule();
         else if (pick < 13) run_single();
         else send_req(rnd_req(3'($urandom_range(0, 6))));
      end
   endtask

   // Receiver stalls on a random pattern, picked anew when the counter's low bits wrap
   int unsigned stall_cnt = 0;
   logic [1:0]  stall_mode = 2'd0;
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt[5:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= 1'($urandom_range(0, 1));
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_cnt[2];
      endcase
   end

   // Compare each accepted response item with the oldest owed one
   lams_pkg::rsp_item_type owed;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response item", 32'd1, 32'd0);
         end else begin
            owed = awaited_rsp.pop_front();
            if (owed.report_valid) n_reports++;
            report_mismatch("led_pins", 32'(rsp_item.led_pins), 32'(owed.led_pins));
            report_mismatch("adc_start_req", 32'(rsp_item.adc_start_req),
                            32'(owed.adc_start_req));
            report_mismatch("adc_stop_req", 32'(rsp_item.adc_stop_req),
                            32'(owed.adc_stop_req));
            report_mismatch("avg_request", 32'(rsp_item.avg_request),
                            32'(owed.avg_request));
            report_mismatch("timeout_error", 32'(rsp_item.timeout_error),
                            32'(owed.timeout_error));
            report_mismatch("report_valid", 32'(rsp_item.report_valid),
                            32'(owed.report_valid));
            report_mismatch("report_mode", 32'(rsp_item.report_mode),
                            32'(owed.report_mode));
            report_mismatch("report_channel", 32'(rsp_item.report_channel),
                            32'(owed.report_channel));
            report_mismatch("report_value", 32'(unsigned'(rsp_item.report_value)),
                            32'(unsigned'(owed.report_value)));
            report_mismatch("report_last", 32'(rsp_item.report_last),
                            32'(owed.report_last));
         end
      end
   end

   // Directed stimulus table
   typedef struct {
      lams_pkg::req_item_type item;
      bit                     typed;
      lams_pkg::rsp_item_type exp;
   } drow_type;

   drow_type dir_rows [$];

   task automatic add_row(input logic [2:0] act, input logic ok,
                          input logic [lams_pkg::MEAS_W-1:0] val, input bit typed,
                          input lams_pkg::rsp_item_type exp);
      drow_type row;
      row.item  = mk_req(act, ok, val);
      row.typed = typed;
      row.exp   = exp;
      dir_rows.push_back(row);
   endtask

   initial begin
      lams_pkg::rsp_item_type rep;
      lams_pkg::rsp_item_type none;
      none = '0;

      cfg_wait    = lams_pkg::WAIT_TICKS_RST;
      cfg_timeout = lams_pkg::TIMEOUT_TICKS_RST;
      cfg_mux     = lams_pkg::MUX_SELECT_RST;
      cfg_len     = lams_pkg::SCHED_LEN_RST;
      cfg_chan    = lams_pkg::SCHED_CHAN_RST;
      clear_task_state();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle task, start handshake and a full single-shot measurement
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_STOP,    1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_START,   1'b0, 24'h000000, 1'b1, mk_status(1'b1, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_START,   1'b1, 24'h000000, 1'b1, mk_status(1'b1, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_START,   1'b1, 24'h000000, 1'b1, mk_status(1'b0, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_MODE3,   1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b1, 1'b0));
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b0, 1'b1));
      add_row(lams_pkg::ACT_RESULT,  1'b0, 24'h7FFFFF, 1'b1, mk_status(1'b0, 1'b0, 1'b0));
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b0, 1'b0));
      rep = mk_status(1'b0, 1'b0, 1'b0);
      rep.report_valid = 1'b1;
      rep.report_mode  = 1'b1;
      rep.report_value = 24'h7FFFFF;
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b1, rep);
      // schedule over all four channels, channel 3 with no pin selected
      add_row(lams_pkg::ACT_MODE1,   1'b1, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_RESULT,  1'b1, 24'h800000, 1'b0, none);
      add_row(lams_pkg::ACT_COLLECT, 1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_COLLECT, 1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_RESULT,  1'b0, 24'hFFFFFF, 1'b0, none);
      add_row(lams_pkg::ACT_COLLECT, 1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_COLLECT, 1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_TICK,    1'b0, 24'h000000, 1'b0, none);
      add_row(lams_pkg::ACT_STOP,    1'b0, 24'h000000, 1'b1, mk_status(1'b0, 1'b1, 1'b0));

      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].item);
         if (dir_rows[i].typed) begin
            awaited_rsp.delete(awaited_rsp.size() - 1);
            awaited_rsp.push_back(dir_rows[i].exp);
         end
      end

      // random runs under a spread of settings, extremes included
      apply_setting(16'd2, 16'd6, 2'd1, 3'd4, 8'($urandom()));
      random_phase(55);
      apply_setting(16'd0, 16'd0, 2'd0, 3'd0, 8'hFF);
      random_phase(50);
      apply_setting(16'd3, 16'd10, 2'd3, 3'd7, 8'($urandom()));
      random_phase(55);
      apply_setting(16'd1, 16'd4, 2'd2, 3'd1, 8'h00);
      random_phase(50);

      // widest limits: a measurement held over a few ticks
      apply_setting(16'hFFFF, 16'hFFFF, 2'($urandom()), 3'd2, 8'($urandom()));
      random_phase(20);
      send_req(mk_req(lams_pkg::ACT_START, 1'b1, 24'h000000));
      send_req(mk_req(lams_pkg::ACT_MODE3, 1'b0, 24'h000000));
      repeat (20) send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'($urandom())));
      send_req(mk_req(lams_pkg::ACT_RESULT, 1'b0, 24'($urandom())));
      send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'h000000));
      send_req(mk_req(lams_pkg::ACT_TICK, 1'b0, 24'h000000));

      apply_setting(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                    2'($urandom()), 3'($urandom_range(0, 7)), 8'($urandom()));
      random_phase(50);
      apply_setting(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                    2'($urandom()), 3'($urandom_range(0, 7)), 8'($urandom()));
      random_phase(50);

      drain();
      $display("Covered %0d request items and %0d response items, %0d of them reports,",
               n_req, n_rsp, n_reports);
      $display("over %0d register settings after the reset values.", n_settings);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop if the block hangs or owes items forever
   initial begin
      #1000000;
      $display("timeout with %0d response items still owed", awaited_rsp.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
